### design/olt_pkg.sv
// olt_pkg: shared types and codes of the ordered list table
// holds the item structs, command and status codes and storage sizes
// no dependencies
package olt_pkg;

   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   localparam logic [2:0] CMD_APPEND    = 3'd0;
   localparam logic [2:0] CMD_GET       = 3'd1;
   localparam logic [2:0] CMD_FIND      = 3'd2;
   localparam logic [2:0] CMD_DEL_FIRST = 3'd3;
   localparam logic [2:0] CMD_DEL_INDEX = 3'd4;
   localparam logic [2:0] CMD_DEL_ALL   = 3'd5;
   localparam logic [2:0] CMD_CLEAR     = 3'd6;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]             cmd;
      logic [VALUE_WIDTH-1:0] value;
      logic [5:0]             position;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [VALUE_WIDTH-1:0] read_value;
      logic [5:0]             found_position;
      logic [6:0]             removed_count;
      logic [6:0]             entry_count;
   } rsp_type;

endpackage

### design/olt_ram.sv
// olt_ram: entry storage of the ordered list table
// one write port, one read port with registered read data
// depends on olt_pkg
module olt_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [olt_pkg::IDX_W-1:0]      wr_addr,
   input  logic [olt_pkg::VALUE_WIDTH-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [olt_pkg::IDX_W-1:0]      rd_addr,
   output logic [olt_pkg::VALUE_WIDTH-1:0] rd_data
);

   logic [olt_pkg::VALUE_WIDTH-1:0] mem [olt_pkg::DEPTH];
   logic [olt_pkg::VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ordered_list_table_core.sv
// ordered_list_table_core: packed ordered list of values with an entry count
// depends on olt_pkg and olt_ram
//
// Usage:
//   An item enters on req_valid / req_stall (accepted when valid and not
//   stalled) and carries a command, a value and a position. Every item
//   yields exactly one result item on rsp_valid / rsp_stall.
//   One item is worked on at a time; req_stall is high while it runs.
//   Path from acceptance to the result showing on rsp:
//     append, clear, unused code, out-of-range get/delete index: from EXEC
//     get: EXEC reads the entry, then GET loads the read data
//     find: a SCAN of the entries, ends at the first match
//     delete first, delete index, delete all: a SCAN of every entry
//   The scans walk the entry memory one entry per cycle through its single
//   read port, the deletes writing kept entries back down through the write
//   port, so the memory port sets the pace; no new item is taken meanwhile.
//   The result sits in an output register; a stalled result holds, and the
//   next item is accepted while it waits but cannot finish until it leaves.
//   Reset empties the list and drops any pending result; the entry memory
//   itself is not cleared, entries are only read after being written.
module ordered_list_table_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  olt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output olt_pkg::rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_GET  = 2'd3;

   localparam int IW = olt_pkg::IDX_W;
   localparam int CW = olt_pkg::CNT_W;
   localparam int VW = olt_pkg::VALUE_WIDTH;

   logic [1:0]    state_ff;
   logic [2:0]    cmd_ff;
   logic [VW-1:0] val_ff;
   logic [IW-1:0] pos_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] rd_idx_ff;
   logic [CW-1:0] wr_idx_ff;
   logic [CW-1:0] removed_ff;
   logic          pend_ff;
   logic [IW-1:0] pend_idx_ff;
   logic          found_ff;
   logic [IW-1:0] fpos_ff;
   logic          rsp_valid_ff;
   olt_pkg::rsp_type rsp_ff;
   olt_pkg::rsp_type rsp_in;

   logic          can_load;
   logic          pos_ok;
   logic          full;
   logic          proc;
   logic          match;
   logic          skip;
   logic          writes_back;
   logic          issue;
   logic          scan_done;
   logic          load;
   logic [VW-1:0] rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic          rd_en;
   logic [IW-1:0] rd_addr;

   olt_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign pos_ok   = {1'b0, pos_ff} < count_ff;
   assign full     = count_ff >= CW'(olt_pkg::DEPTH);

   // scan: data for entry pend_idx_ff arrives in the cycle after its read
   assign proc  = (state_ff == ST_SCAN) && pend_ff && !found_ff;
   assign match = rd_data == val_ff;

   always_comb begin
      case (cmd_ff)
         olt_pkg::CMD_DEL_FIRST: skip = match && (removed_ff == '0);
         olt_pkg::CMD_DEL_INDEX: skip = pend_idx_ff == pos_ff;
         olt_pkg::CMD_DEL_ALL:   skip = match;
         default:                skip = 1'b0;
      endcase
   end

   assign writes_back = cmd_ff != olt_pkg::CMD_FIND;

   // stop issuing reads once find has its match
   assign issue = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff) && !found_ff
                  && !(proc && match && (cmd_ff == olt_pkg::CMD_FIND));

   assign scan_done = (state_ff == ST_SCAN) && !pend_ff
                      && ((rd_idx_ff == count_ff) || found_ff);

   // memory ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_idx_ff[IW-1:0];
      wr_data = rd_data;
      rd_en   = 1'b0;
      rd_addr = rd_idx_ff[IW-1:0];
      if (state_ff == ST_EXEC) begin
         if (cmd_ff == olt_pkg::CMD_APPEND) begin
            wr_en   = can_load && !full;
            wr_addr = count_ff[IW-1:0];
            wr_data = val_ff;
         end
         if (cmd_ff == olt_pkg::CMD_GET) begin
            rd_en   = pos_ok;
            rd_addr = pos_ff;
         end
      end else if (state_ff == ST_SCAN) begin
         wr_en = proc && !skip && writes_back;
         rd_en = issue;
      end
   end

   // result and load decision
   always_comb begin
      load   = 1'b0;
      rsp_in = '0;
      rsp_in.entry_count = count_ff;
      case (state_ff)
         ST_EXEC: begin
            case (cmd_ff)
               olt_pkg::CMD_APPEND: begin
                  load = can_load;
                  if (full) begin
                     rsp_in.status = olt_pkg::STATUS_FULL;
                  end else begin
                     rsp_in.entry_count = count_ff + CW'(1);
                  end
               end
               olt_pkg::CMD_GET: begin
                  load = can_load && !pos_ok;
                  rsp_in.status = olt_pkg::STATUS_MISS;
               end
               olt_pkg::CMD_DEL_INDEX: begin
                  load = can_load && !pos_ok;
                  rsp_in.status = olt_pkg::STATUS_MISS;
               end
               olt_pkg::CMD_CLEAR: begin
                  load = can_load;
                  rsp_in.removed_count = count_ff;
                  rsp_in.entry_count   = '0;
               end
               olt_pkg::CMD_FIND, olt_pkg::CMD_DEL_FIRST, olt_pkg::CMD_DEL_ALL: begin
                  load = 1'b0;
               end
               default: begin
                  load = can_load;
                  rsp_in.status = olt_pkg::STATUS_MISS;
               end
            endcase
         end
         ST_GET: begin
            load = can_load;
            rsp_in.read_value = rd_data;
         end
         ST_SCAN: begin
            load = scan_done && can_load;
            rsp_in.removed_count = removed_ff;
            rsp_in.entry_count   = count_ff - removed_ff;
            if (cmd_ff == olt_pkg::CMD_FIND) begin
               if (found_ff) begin
                  rsp_in.found_position = fpos_ff;
               end else begin
                  rsp_in.status = olt_pkg::STATUS_MISS;
               end
            end else if (cmd_ff == olt_pkg::CMD_DEL_FIRST && removed_ff == '0) begin
               rsp_in.status = olt_pkg::STATUS_MISS;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= rsp_in.entry_count;
            state_ff     <= ST_IDLE;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rd_idx_ff  <= '0;
               wr_idx_ff  <= '0;
               removed_ff <= '0;
               pend_ff    <= 1'b0;
               found_ff   <= 1'b0;
               if (cmd_ff == olt_pkg::CMD_GET && pos_ok) begin
                  state_ff <= ST_GET;
               end
               if (cmd_ff == olt_pkg::CMD_FIND || cmd_ff == olt_pkg::CMD_DEL_FIRST
                   || cmd_ff == olt_pkg::CMD_DEL_ALL
                   || (cmd_ff == olt_pkg::CMD_DEL_INDEX && pos_ok)) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               pend_ff <= issue;
               if (issue) begin
                  rd_idx_ff   <= rd_idx_ff + CW'(1);
                  pend_idx_ff <= rd_idx_ff[IW-1:0];
               end
               if (proc) begin
                  if (cmd_ff == olt_pkg::CMD_FIND) begin
                     if (match) begin
                        found_ff <= 1'b1;
                        fpos_ff  <= pend_idx_ff;
                     end
                  end else if (skip) begin
                     removed_ff <= removed_ff + CW'(1);
                  end else begin
                     wr_idx_ff <= wr_idx_ff + CW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_ff <= req_data.cmd;
         val_ff <= req_data.value;
         pos_ff <= req_data.position;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
